// ===== sv/qslerp_pkg.sv =====
// shared types, constants and the arctangent table of the slerp pipeline
package qslerp_pkg;

    localparam int FRAC_BITS         = 30;
    localparam int CORDIC_STAGES_DEF = 28;
    localparam int CW                = 34;          // cordic datapath width
    localparam int SQ_BITS           = 31;          // root digits
    localparam int K_BITS            = 31;          // weight quotient digits
    localparam int LAT_FIX           = 5 + SQ_BITS + 1 + K_BITS + 3;

    localparam logic [30:0] ONE       = 31'(1) << FRAC_BITS;
    localparam logic [30:0] THR_RESET = 31'd1073634450;
    localparam logic signed [CW-1:0] GAIN = 34'sd652032874;

    typedef struct packed {
        logic [3:0][31:0] a;
        logic [3:0][32:0] b;
        logic [30:0]      kl0;
        logic [30:0]      kl1;
        logic [31:0]      t;
        logic [30:0]      c;
        logic [30:0]      s;
        logic             lin;
    } t_side;

    // arctangent of 2^-i in q30 radians
    function automatic logic [29:0] atan_q30(input int idx);
        logic [29:0] v;
        case (idx)
            0:  v = 30'd843314857;
            1:  v = 30'd497837829;
            2:  v = 30'd263043837;
            3:  v = 30'd133525159;
            4:  v = 30'd67021687;
            5:  v = 30'd33543516;
            6:  v = 30'd16775851;
            7:  v = 30'd8388437;
            8:  v = 30'd4194283;
            9:  v = 30'd2097149;
            10: v = 30'd1048576;
            11: v = 30'd524288;
            12: v = 30'd262144;
            13: v = 30'd131072;
            14: v = 30'd65536;
            15: v = 30'd32768;
            16: v = 30'd16384;
            17: v = 30'd8192;
            18: v = 30'd4096;
            19: v = 30'd2048;
            20: v = 30'd1024;
            21: v = 30'd512;
            22: v = 30'd256;
            23: v = 30'd128;
            24: v = 30'd64;
            25: v = 30'd32;
            26: v = 30'd16;
            27: v = 30'd8;
            28: v = 30'd4;
            29: v = 30'd2;
            30: v = 30'd1;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== sv/qslerp_digit.sv =====
// pipelined digit recurrence: integer square root or unsigned divide, one bit a stage
module qslerp_digit import qslerp_pkg::*; #(
    parameter int STEPS   = 31,
    parameter bit IS_ROOT = 1'b0,
    parameter int LANES   = 1,
    parameter int SW      = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  logic [63:0]       i_num [LANES],
    input  logic [30:0]       i_den [LANES],
    input  logic [SW-1:0]     i_side,
    output logic              o_vld,
    output logic [STEPS-1:0]  o_res [LANES],
    output logic [SW-1:0]     o_side
);

    logic             r_vld  [STEPS];
    logic [SW-1:0]    r_side [STEPS];
    logic [63:0]      r_rem  [STEPS][LANES];
    logic [STEPS-1:0] r_q    [STEPS][LANES];
    logic [30:0]      r_den  [STEPS][LANES];

    for (genvar g = 0; g < STEPS; g++) begin : g_st
        localparam int B = STEPS - 1 - g;
        logic             p_vld;
        logic [SW-1:0]    p_side;
        logic [63:0]      p_rem [LANES];
        logic [STEPS-1:0] p_q   [LANES];
        logic [30:0]      p_den [LANES];

        if (g == 0) begin : g_in
            assign p_vld  = i_vld;
            assign p_side = i_side;
            for (genvar l = 0; l < LANES; l++) begin : g_l
                assign p_rem[l] = i_num[l];
                assign p_q[l]   = '0;
                assign p_den[l] = i_den[l];
            end
        end else begin : g_mid
            assign p_vld  = r_vld[g-1];
            assign p_side = r_side[g-1];
            for (genvar l = 0; l < LANES; l++) begin : g_l
                assign p_rem[l] = r_rem[g-1][l];
                assign p_q[l]   = r_q[g-1][l];
                assign p_den[l] = r_den[g-1][l];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else begin
                r_vld[g] <= p_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            r_side[g] <= p_side;
        end

        for (genvar l = 0; l < LANES; l++) begin : g_lane
            logic [63:0]      trial;
            logic             ge;
            logic [63:0]      n_rem;
            logic [STEPS-1:0] n_q;

            if (IS_ROOT) begin : g_root
                // (root + 2^B)^2 - root^2
                assign trial = (64'(p_q[l]) << (B + 1)) + (64'd1 << (2 * B));
            end else begin : g_div
                assign trial = 64'(p_den[l]) << B;
            end

            always_comb begin
                ge    = p_rem[l] >= trial;
                n_rem = ge ? p_rem[l] - trial : p_rem[l];
                n_q   = ge ? (p_q[l] | (STEPS'(1) << B)) : p_q[l];
            end

            always_ff @(posedge i_clk) begin
                r_rem[g][l] <= n_rem;
                r_q[g][l]   <= n_q;
                r_den[g][l] <= p_den[l];
            end
        end
    end

    assign o_vld  = r_vld[STEPS-1];
    assign o_side = r_side[STEPS-1];
    for (genvar l = 0; l < LANES; l++) begin : g_out
        assign o_res[l] = r_q[STEPS-1][l];
    end

endmodule

// ===== sv/qslerp_cordic.sv =====
// pipelined cordic, vectoring (atan2) or rotation (sine), one micro-rotation a stage
module qslerp_cordic import qslerp_pkg::*; #(
    parameter int STAGES = CORDIC_STAGES_DEF,
    parameter bit VECTOR = 1'b0,
    parameter int LANES  = 1,
    parameter int SW     = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_vld,
    input  logic signed [CW-1:0] i_x [LANES],
    input  logic signed [CW-1:0] i_y [LANES],
    input  logic signed [CW-1:0] i_z [LANES],
    input  logic [SW-1:0]        i_side,
    output logic                 o_vld,
    output logic signed [CW-1:0] o_y [LANES],
    output logic signed [CW-1:0] o_z [LANES],
    output logic [SW-1:0]        o_side
);

    logic                 r_vld  [STAGES];
    logic [SW-1:0]        r_side [STAGES];
    logic signed [CW-1:0] r_x    [STAGES][LANES];
    logic signed [CW-1:0] r_y    [STAGES][LANES];
    logic signed [CW-1:0] r_z    [STAGES][LANES];

    for (genvar g = 0; g < STAGES; g++) begin : g_st
        localparam logic signed [CW-1:0] AT = CW'(atan_q30(g));
        logic                 p_vld;
        logic [SW-1:0]        p_side;
        logic signed [CW-1:0] p_x [LANES];
        logic signed [CW-1:0] p_y [LANES];
        logic signed [CW-1:0] p_z [LANES];

        if (g == 0) begin : g_in
            assign p_vld  = i_vld;
            assign p_side = i_side;
            for (genvar l = 0; l < LANES; l++) begin : g_l
                assign p_x[l] = i_x[l];
                assign p_y[l] = i_y[l];
                assign p_z[l] = i_z[l];
            end
        end else begin : g_mid
            assign p_vld  = r_vld[g-1];
            assign p_side = r_side[g-1];
            for (genvar l = 0; l < LANES; l++) begin : g_l
                assign p_x[l] = r_x[g-1][l];
                assign p_y[l] = r_y[g-1][l];
                assign p_z[l] = r_z[g-1][l];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else begin
                r_vld[g] <= p_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            r_side[g] <= p_side;
        end

        for (genvar l = 0; l < LANES; l++) begin : g_lane
            logic                 up;
            logic signed [CW-1:0] dx;
            logic signed [CW-1:0] dy;
            logic signed [CW-1:0] n_x;
            logic signed [CW-1:0] n_y;
            logic signed [CW-1:0] n_z;

            always_comb begin
                dx = p_y[l] >>> g;
                dy = p_x[l] >>> g;
                // vectoring drives y to zero, rotation drives z to zero
                up = VECTOR ? !p_y[l][CW-1] : !p_z[l][CW-1];
                if (up == VECTOR) begin
                    n_x = p_x[l] + dx;
                    n_y = p_y[l] - dy;
                end else begin
                    n_x = p_x[l] - dx;
                    n_y = p_y[l] + dy;
                end
                n_z = up ? p_z[l] + (VECTOR ? AT : -AT) : p_z[l] - (VECTOR ? AT : -AT);
            end

            always_ff @(posedge i_clk) begin
                r_x[g][l] <= n_x;
                r_y[g][l] <= n_y;
                r_z[g][l] <= n_z;
            end
        end
    end

    assign o_vld  = r_vld[STAGES-1];
    assign o_side = r_side[STAGES-1];
    for (genvar l = 0; l < LANES; l++) begin : g_out
        assign o_y[l] = r_y[STAGES-1][l];
        assign o_z[l] = r_z[STAGES-1][l];
    end

endmodule

// ===== sv/quaternion_slerp.sv =====
// quaternion slerp top level: dot, root, atan2, sines, weights and blend in one pipeline
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+---------------------------------------------
//  input    | start, busy               | i_from_x..w, i_to_x..w, i_fraction (q2.30)
//  result   | o_valid (one-cycle strobe)| o_out_x..w (q2.30, saturated)
//  config   | i_cfg_we                  | i_cfg_wdata (near threshold, q1.30)
//
// one item enters per clock; each transfer passes through the root, divide (one digit a
// stage) and cordic stages before its result leaves.
// reset is synchronous and clears the valid bits; busy is high only during reset.
// the pipeline never stalls: the result side takes every strobe.
module quaternion_slerp import qslerp_pkg::*; #(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] i_from_x,
    input  logic signed [31:0] i_from_y,
    input  logic signed [31:0] i_from_z,
    input  logic signed [31:0] i_from_w,
    input  logic signed [31:0] i_to_x,
    input  logic signed [31:0] i_to_y,
    input  logic signed [31:0] i_to_z,
    input  logic signed [31:0] i_to_w,
    input  logic signed [31:0] i_fraction,
    input  logic               i_cfg_we,
    input  logic [30:0]        i_cfg_wdata,
    output logic               o_valid,
    output logic signed [31:0] o_out_x,
    output logic signed [31:0] o_out_y,
    output logic signed [31:0] o_out_z,
    output logic signed [31:0] o_out_w
);

    localparam int DSW = $bits(t_side) + 2;

    logic [30:0] r_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_wdata;
        end
    end

    assign busy = ~i_rst_n;

    // stage 1: input register
    logic              r1_v;
    logic [3:0][31:0]  r1_a;
    logic [3:0][31:0]  r1_b;
    logic [31:0]       r1_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else begin
            r1_v <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_a <= {i_from_w, i_from_z, i_from_y, i_from_x};
        r1_b <= {i_to_w, i_to_z, i_to_y, i_to_x};
        r1_t <= i_fraction;
    end

    // stage 2: products of the dot, fraction decode
    logic               r2_v;
    logic signed [63:0] r2_p [4];
    t_side              r2_side;
    t_side              n2_side;
    logic               lo_t;
    logic               hi_t;

    always_comb begin
        lo_t = $signed(r1_t) <= 32'sd0;
        hi_t = $signed(r1_t) >= $signed({1'b0, ONE});
        n2_side   = '0;
        n2_side.a = r1_a;
        for (int j = 0; j < 4; j++) begin
            n2_side.b[j] = {r1_b[j][31], r1_b[j]};
        end
        n2_side.t   = r1_t;
        n2_side.lin = lo_t || hi_t;
        if (lo_t) begin
            n2_side.kl0 = ONE;
            n2_side.kl1 = '0;
        end else if (hi_t) begin
            n2_side.kl0 = '0;
            n2_side.kl1 = ONE;
        end else begin
            n2_side.kl0 = ONE - r1_t[30:0];
            n2_side.kl1 = r1_t[30:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 4; j++) begin
            r2_p[j] <= $signed(r1_a[j]) * $signed(r1_b[j]);
        end
        r2_side <= n2_side;
    end

    // stage 3: dot sum
    logic               r3_v;
    logic signed [35:0] r3_dot;
    t_side              r3_side;
    logic signed [63:0] n3_sum;

    assign n3_sum = (r2_p[0] >>> 2) + (r2_p[1] >>> 2) + (r2_p[2] >>> 2) + (r2_p[3] >>> 2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_dot  <= n3_sum[63:28];
        r3_side <= r2_side;
    end

    // stage 4: hemisphere flip, threshold, cosine clamp
    logic               r4_v;
    t_side              r4_side;
    t_side              n4_side;
    logic               neg;
    logic signed [35:0] absd;

    always_comb begin
        n4_side = r3_side;
        neg     = !r3_side.lin && r3_dot[35];
        absd    = neg ? -r3_dot : r3_dot;
        for (int j = 0; j < 4; j++) begin
            n4_side.b[j] = neg ? 33'(-$signed(r3_side.b[j])) : r3_side.b[j];
        end
        n4_side.lin = r3_side.lin || (absd > $signed(36'(r_thr)));
        n4_side.c   = (absd > $signed(36'(ONE))) ? ONE : absd[30:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else begin
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r4_side <= n4_side;
    end

    // stage 5: cosine squared
    logic        r5_v;
    logic [61:0] r5_csq;
    t_side       r5_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else begin
            r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r5_csq  <= r4_side.c * r4_side.c;
        r5_side <= r4_side;
    end

    // sine of the angle as sqrt(1 - c^2)
    logic [63:0]         rt_num [1];
    logic [30:0]         rt_den [1];
    logic                rt_vld;
    logic [SQ_BITS-1:0]  rt_res [1];
    logic [$bits(t_side)-1:0] rt_side;

    assign rt_num[0] = (64'd1 << (2 * FRAC_BITS)) - 64'(r5_csq);
    assign rt_den[0] = '0;

    qslerp_digit #(
        .STEPS   (SQ_BITS),
        .IS_ROOT (1'b1),
        .LANES   (1),
        .SW      ($bits(t_side))
    ) u_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r5_v),
        .i_num   (rt_num),
        .i_den   (rt_den),
        .i_side  (r5_side),
        .o_vld   (rt_vld),
        .o_res   (rt_res),
        .o_side  (rt_side)
    );

    // angle by atan2(s, c)
    t_side                at_in_side;
    logic signed [CW-1:0] at_x [1];
    logic signed [CW-1:0] at_y [1];
    logic signed [CW-1:0] at_z [1];
    logic                 at_vld;
    logic signed [CW-1:0] at_oy [1];
    logic signed [CW-1:0] at_oz [1];
    logic [$bits(t_side)-1:0] at_side;
    t_side                at_out_side;

    always_comb begin
        at_in_side     = t_side'(rt_side);
        at_in_side.s   = rt_res[0];
        // zero sine falls back to the linear weights
        at_in_side.lin = at_in_side.lin || (rt_res[0] == '0);
    end

    assign at_x[0] = CW'(at_in_side.c);
    assign at_y[0] = CW'(rt_res[0]);
    assign at_z[0] = '0;

    qslerp_cordic #(
        .STAGES  (CORDIC_STAGES),
        .VECTOR  (1'b1),
        .LANES   (1),
        .SW      ($bits(t_side))
    ) u_atan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (rt_vld),
        .i_x     (at_x),
        .i_y     (at_y),
        .i_z     (at_z),
        .i_side  (at_in_side),
        .o_vld   (at_vld),
        .o_y     (at_oy),
        .o_z     (at_oz),
        .o_side  (at_side)
    );

    assign at_out_side = t_side'(at_side);

    // stage 7: t * angle
    logic                 r7_v;
    logic signed [65:0]   r7_prod;
    logic signed [CW-1:0] r7_w;
    t_side                r7_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_v <= 1'b0;
        end else begin
            r7_v <= at_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r7_prod <= $signed(at_out_side.t) * at_oz[0];
        r7_w    <= at_oz[0];
        r7_side <= at_out_side;
    end

    // sines of both partial angles
    logic signed [CW-1:0] sn_x [2];
    logic signed [CW-1:0] sn_y [2];
    logic signed [CW-1:0] sn_z [2];
    logic signed [CW-1:0] a1;
    logic                 sn_vld;
    logic signed [CW-1:0] sn_oy [2];
    logic signed [CW-1:0] sn_oz [2];
    logic [$bits(t_side)-1:0] sn_side;
    t_side                sn_out_side;

    assign a1      = r7_prod[63:30];
    assign sn_x[0] = GAIN;
    assign sn_x[1] = GAIN;
    assign sn_y[0] = '0;
    assign sn_y[1] = '0;
    assign sn_z[0] = r7_w - a1;
    assign sn_z[1] = a1;

    qslerp_cordic #(
        .STAGES  (CORDIC_STAGES),
        .VECTOR  (1'b0),
        .LANES   (2),
        .SW      ($bits(t_side))
    ) u_sine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r7_v),
        .i_x     (sn_x),
        .i_y     (sn_y),
        .i_z     (sn_z),
        .i_side  (r7_side),
        .o_vld   (sn_vld),
        .o_y     (sn_oy),
        .o_z     (sn_oz),
        .o_side  (sn_side)
    );

    assign sn_out_side = t_side'(sn_side);

    // weights sin / s, clamped to one
    logic [32:0]        snp [2];
    logic [1:0]         over;
    logic [63:0]        dv_num [2];
    logic [30:0]        dv_den [2];
    logic               dv_vld;
    logic [K_BITS-1:0]  dv_q [2];
    logic [DSW-1:0]     dv_side;
    t_side              dv_out_side;
    logic [1:0]         dv_over;

    for (genvar k = 0; k < 2; k++) begin : g_wt
        assign snp[k]    = sn_oy[k][CW-1] ? 33'd0 : sn_oy[k][32:0];
        assign over[k]   = snp[k] > 33'(sn_out_side.s);
        assign dv_num[k] = 64'({snp[k], 30'd0});
        assign dv_den[k] = sn_out_side.s;
    end

    qslerp_digit #(
        .STEPS   (K_BITS),
        .IS_ROOT (1'b0),
        .LANES   (2),
        .SW      (DSW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (sn_vld),
        .i_num   (dv_num),
        .i_den   (dv_den),
        .i_side  ({sn_out_side, over}),
        .o_vld   (dv_vld),
        .o_res   (dv_q),
        .o_side  (dv_side)
    );

    assign dv_out_side = t_side'(dv_side[DSW-1:2]);
    assign dv_over     = dv_side[1:0];

    // stage 10: weight select
    logic        r10_v;
    logic [30:0] r10_k0;
    logic [30:0] r10_k1;
    t_side       r10_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r10_v <= 1'b0;
        end else begin
            r10_v <= dv_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r10_k0   <= dv_out_side.lin ? dv_out_side.kl0 : (dv_over[0] ? ONE : dv_q[0]);
        r10_k1   <= dv_out_side.lin ? dv_out_side.kl1 : (dv_over[1] ? ONE : dv_q[1]);
        r10_side <= dv_out_side;
    end

    // stage 11: weighted products
    logic               r11_v;
    logic signed [63:0] r11_pa [4];
    logic signed [64:0] r11_pb [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r11_v <= 1'b0;
        end else begin
            r11_v <= r10_v;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 4; j++) begin
            r11_pa[j] <= $signed({1'b0, r10_k0}) * $signed(r10_side.a[j]);
            r11_pb[j] <= $signed({1'b0, r10_k1}) * $signed(r10_side.b[j]);
        end
    end

    // stage 12: round, saturate, output register
    logic signed [65:0] sum [4];
    logic signed [35:0] shv [4];
    logic [3:0][31:0]   n_out;

    always_comb begin
        for (int j = 0; j < 4; j++) begin
            sum[j] = 66'(r11_pa[j]) + 66'(r11_pb[j]) + (66'sd1 <<< (FRAC_BITS - 1));
            shv[j] = sum[j][65:30];
            if (shv[j] > 36'sd2147483647) begin
                n_out[j] = 32'h7fff_ffff;
            end else if (shv[j] < -36'sd2147483648) begin
                n_out[j] = 32'h8000_0000;
            end else begin
                n_out[j] = shv[j][31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r11_v;
        end
    end

    always_ff @(posedge i_clk) begin
        o_out_x <= n_out[0];
        o_out_y <= n_out[1];
        o_out_z <= n_out[2];
        o_out_w <= n_out[3];
    end

endmodule

// ===== sv/qslerp_chk.sv =====
// port-level checker for the slerp pipeline, bound to the top level
module qslerp_chk import qslerp_pkg::*; #(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic signed [31:0] i_from_x,
    input logic signed [31:0] i_from_w,
    input logic signed [31:0] i_to_y,
    input logic signed [31:0] i_fraction,
    input logic               o_valid,
    input logic signed [31:0] o_out_x,
    input logic signed [31:0] o_out_y,
    input logic signed [31:0] o_out_w
);

    localparam int LAT = LAT_FIX + 2 * CORDIC_STAGES;

    logic acc;
    assign acc = start && !busy;

    a_lat : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |-> ##LAT o_valid)
        else $error("transfer without result after pipeline latency");

    a_src : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(acc, LAT))
        else $error("result strobe without matching transfer");

    a_lo : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && (i_fraction <= 32'sd0) |-> ##LAT
            (o_out_x == $past(i_from_x, LAT)) && (o_out_w == $past(i_from_w, LAT)))
        else $error("fraction at or below zero did not return first quaternion");

    a_hi : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && (i_fraction >= $signed({1'b0, ONE})) |-> ##LAT
            (o_out_y == $past(i_to_y, LAT)))
        else $error("fraction at or above one did not return second quaternion");

endmodule

bind quaternion_slerp qslerp_chk #(.CORDIC_STAGES(CORDIC_STAGES)) u_qslerp_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .start      (start),
    .busy       (busy),
    .i_from_x   (i_from_x),
    .i_from_w   (i_from_w),
    .i_to_y     (i_to_y),
    .i_fraction (i_fraction),
    .o_valid    (o_valid),
    .o_out_x    (o_out_x),
    .o_out_y    (o_out_y),
    .o_out_w    (o_out_w)
);
